// ----- design/chained_byte_scrambler_defines.svh -----
// Assertion macros for the chained byte scrambler
`ifndef CHAINED_BYTE_SCRAMBLER_DEFINES_SVH
`define CHAINED_BYTE_SCRAMBLER_DEFINES_SVH

// Check that cons holds in the cycle after ante.
`define CBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scrambler check failed");

// Check that cons holds in the same cycle as ante.
`define CBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scrambler check failed");

`endif

// ----- design/cbs_pkg.sv -----
// Shared types, constants and rotate helpers for the chained byte scrambler
package cbs_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned KeyW    = 32;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned Rounds  = 7;
	localparam int unsigned AddW    = 5;
	localparam int unsigned ShiftW  = 3;

	typedef logic [ByteW-1:0] byte_t;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} reg_idx_t;

	function automatic byte_t rotl8(input byte_t v, input logic [ShiftW-1:0] s);
		logic [2*ByteW-1:0] w;
		begin
			w = {v, v} << s;
			return w[2*ByteW-1:ByteW];
		end
	endfunction

	function automatic byte_t rotr8(input byte_t v, input logic [ShiftW-1:0] s);
		logic [2*ByteW-1:0] w;
		begin
			w = {v, v} >> s;
			return w[ByteW-1:0];
		end
	endfunction

endpackage

// ----- design/cbs_core.sv -----
// Combinational encode and decode datapath of one byte
module cbs_core (
	input  logic                          operation,
	input  cbs_pkg::byte_t                data_byte,
	input  cbs_pkg::byte_t                chain,
	input  logic [cbs_pkg::KeyW-1:0]      key_low,
	input  logic [cbs_pkg::KeyW-1:0]      key_high,
	output cbs_pkg::byte_t                result_byte
);

	logic [2*cbs_pkg::KeyW-1:0] key;
	cbs_pkg::byte_t             enc;
	cbs_pkg::byte_t             dec;
	cbs_pkg::byte_t             kb;
	cbs_pkg::byte_t             add0;

	assign key  = {key_high, key_low};
	assign add0 = key[cbs_pkg::ByteW-1:0];

	always_comb begin
		enc = (data_byte ^ chain) + add0;
		kb  = '0;
		for (int r = 1; r <= cbs_pkg::Rounds; r++) begin
			kb  = key[r*cbs_pkg::ByteW +: cbs_pkg::ByteW];
			enc = cbs_pkg::rotl8(enc, kb[cbs_pkg::ByteW-1 -: cbs_pkg::ShiftW]);
			enc = enc + {{(cbs_pkg::ByteW-cbs_pkg::AddW){1'b0}}, kb[cbs_pkg::AddW-1:0]};
		end
		dec = data_byte;
		for (int r = cbs_pkg::Rounds; r >= 1; r--) begin
			kb  = key[r*cbs_pkg::ByteW +: cbs_pkg::ByteW];
			dec = dec - {{(cbs_pkg::ByteW-cbs_pkg::AddW){1'b0}}, kb[cbs_pkg::AddW-1:0]};
			dec = cbs_pkg::rotr8(dec, kb[cbs_pkg::ByteW-1 -: cbs_pkg::ShiftW]);
		end
		dec = (dec - add0) ^ chain;
	end

	assign result_byte = (cbs_pkg::op_t'(operation) == cbs_pkg::OP_DECODE) ? dec : enc;

endmodule

// ----- design/chained_byte_scrambler.sv -----
// Top level of the chained byte scrambler
// Usage:
//   Input channel (in_valid/in_ready) carries operation, data_byte, first and seed.
//   Output channel (out_valid/out_ready) carries result_byte, one per input byte.
//   Config channel (cfg_valid/cfg_ready) writes key_low (index 0) or key_high
//   (index 1); cfg_ready is always high. Write keys only while the block is idle.
//   Each input transfer lands in an input register; the combinational encode or decode
//   pass runs from there into the result register, which also updates the chain
//   byte. out_valid is registered and rises when the result register is loaded.
//   Throughput is one byte per cycle while the receiver does not stall.
//   A byte with first set uses seed as chain; otherwise the previous chain is used.
//   When the receiver stalls, the result is held and the input register fills;
//   in_ready then drops until the result is taken.
//   Reset clears the keys, the chain byte and both valid flags.
module chained_byte_scrambler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [cbs_pkg::ByteW-1:0]        data_byte,
	input  logic                             first,
	input  logic [cbs_pkg::ByteW-1:0]        seed,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cbs_pkg::ByteW-1:0]        result_byte,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cbs_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [cbs_pkg::KeyW-1:0]         cfg_data
);

	`include "chained_byte_scrambler_defines.svh"

	logic                       valid_s1;
	logic                       op_s1;
	cbs_pkg::byte_t             data_s1;
	logic                       first_s1;
	cbs_pkg::byte_t             seed_s1;
	logic                       out_valid_q;
	cbs_pkg::byte_t             result_q;
	cbs_pkg::byte_t             chain_q;
	logic [cbs_pkg::KeyW-1:0]   key_low_q;
	logic [cbs_pkg::KeyW-1:0]   key_high_q;
	cbs_pkg::byte_t             chain_sel;
	cbs_pkg::byte_t             core_res;
	logic                       advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid   = out_valid_q;
	assign result_byte = result_q;
	assign chain_sel   = first_s1 ? seed_s1 : chain_q;

	cbs_core u_core (
		.operation   (op_s1),
		.data_byte   (data_s1),
		.chain       (chain_sel),
		.key_low     (key_low_q),
		.key_high    (key_high_q),
		.result_byte (core_res)
	);

	// Keys
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cbs_pkg::reg_idx_t'(cfg_index))
				cbs_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				cbs_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= operation;
			data_s1  <= data_byte;
			first_s1 <= first;
			seed_s1  <= seed;
		end
	end

	// Result register and chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			chain_q     <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				chain_q     <= (cbs_pkg::op_t'(op_s1) == cbs_pkg::OP_DECODE) ?
					data_s1 : core_res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_res;
		end
	end

	`CBS_ASSERT_NEXT(a_in_lands, in_valid && in_ready, valid_s1)
	`CBS_ASSERT_NEXT(a_enc_chain, advance && !op_s1, chain_q == result_q && out_valid_q)
	`CBS_ASSERT_NEXT(a_dec_chain, advance && op_s1, chain_q == $past(data_s1))
	`CBS_ASSERT_NOW(a_full_blocks, valid_s1 && out_valid_q && !out_ready, !in_ready)

endmodule

// ----- verif/chained_byte_scrambler_tb.sv -----
// Self-checking testbench for the chained byte scrambler: directed table, random packets
module chained_byte_scrambler_tb;

	localparam int unsigned LIMIT       = 200000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASES      = 6;
	localparam int unsigned PHASE_ITEMS = 300;
	localparam int unsigned DIR_N       = 20;
	localparam int unsigned KEY_ROW_A   = 8;
	localparam int unsigned KEY_ROW_B   = 14;

	typedef struct packed {
		cbs_pkg::op_t   op;
		cbs_pkg::byte_t data;
		logic           first;
		cbs_pkg::byte_t seed;
		logic           typed;
		cbs_pkg::byte_t want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{cbs_pkg::OP_ENCODE, 8'h3C, 1'b0, 8'h00, 1'b1, 8'h3C},
		'{cbs_pkg::OP_ENCODE, 8'hFF, 1'b0, 8'h77, 1'b1, 8'hC3},
		'{cbs_pkg::OP_ENCODE, 8'h00, 1'b1, 8'hFF, 1'b1, 8'hFF},
		'{cbs_pkg::OP_ENCODE, 8'h80, 1'b0, 8'h00, 1'b1, 8'h7F},
		'{cbs_pkg::OP_DECODE, 8'h12, 1'b1, 8'h34, 1'b1, 8'h26},
		'{cbs_pkg::OP_DECODE, 8'hFF, 1'b0, 8'hAA, 1'b1, 8'hED},
		'{cbs_pkg::OP_DECODE, 8'h00, 1'b0, 8'h00, 1'b1, 8'hFF},
		'{cbs_pkg::OP_DECODE, 8'h01, 1'b1, 8'h80, 1'b1, 8'h81},
		'{cbs_pkg::OP_ENCODE, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{cbs_pkg::OP_ENCODE, 8'hFF, 1'b0, 8'hFF, 1'b0, 8'h00},
		'{cbs_pkg::OP_ENCODE, 8'h55, 1'b0, 8'h00, 1'b0, 8'h00},
		'{cbs_pkg::OP_DECODE, 8'h00, 1'b1, 8'hFF, 1'b0, 8'h00},
		'{cbs_pkg::OP_DECODE, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00},
		'{cbs_pkg::OP_DECODE, 8'hAA, 1'b0, 8'h55, 1'b0, 8'h00},
		'{cbs_pkg::OP_ENCODE, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00},
		'{cbs_pkg::OP_ENCODE, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00},
		'{cbs_pkg::OP_ENCODE, 8'h3C, 1'b0, 8'hC3, 1'b0, 8'h00},
		'{cbs_pkg::OP_DECODE, 8'h00, 1'b1, 8'hFF, 1'b0, 8'h00},
		'{cbs_pkg::OP_DECODE, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00},
		'{cbs_pkg::OP_DECODE, 8'h5A, 1'b0, 8'h00, 1'b0, 8'h00}
	};

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic                        operation = 1'b0;
	logic [cbs_pkg::ByteW-1:0]   data_byte = '0;
	logic                        first     = 1'b0;
	logic [cbs_pkg::ByteW-1:0]   seed      = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [cbs_pkg::ByteW-1:0]   result_byte;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [cbs_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [cbs_pkg::KeyW-1:0]    cfg_data  = '0;

	logic [cbs_pkg::KeyW-1:0] key_low_q  = '0;
	logic [cbs_pkg::KeyW-1:0] key_high_q = '0;
	cbs_pkg::byte_t           chain_q    = '0;
	cbs_pkg::byte_t           result_q[$];
	cbs_pkg::byte_t           want_byte;

	int unsigned err_cnt    = 0;
	int unsigned cycle_cnt  = 0;
	int unsigned burst_left = 0;
	logic        steady     = 1'b0;
	logic        hold_req   = 1'b0;
	int unsigned hold_left  = 0;
	int unsigned mode_left  = 0;
	int unsigned stall_mode = 0;
	logic [7:0]  stall_pat  = 8'hFF;
	logic [2:0]  pat_idx    = '0;

	chained_byte_scrambler u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.data_byte   (data_byte),
		.first       (first),
		.seed        (seed),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_byte (result_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic cbs_pkg::byte_t rol_byte(cbs_pkg::byte_t v,
			logic [cbs_pkg::ShiftW-1:0] s);
		return (v << s) | (v >> (cbs_pkg::ByteW - s));
	endfunction

	function automatic cbs_pkg::byte_t ror_byte(cbs_pkg::byte_t v,
			logic [cbs_pkg::ShiftW-1:0] s);
		return (v >> s) | (v << (cbs_pkg::ByteW - s));
	endfunction

	function automatic cbs_pkg::byte_t key_byte(int unsigned idx);
		logic [cbs_pkg::KeyW-1:0] word;
		word = (idx < 4) ? key_low_q : key_high_q;
		return word[(idx % 4) * cbs_pkg::ByteW +: cbs_pkg::ByteW];
	endfunction

	function automatic cbs_pkg::byte_t scramble_byte(cbs_pkg::op_t op, cbs_pkg::byte_t data,
			logic first_in, cbs_pkg::byte_t seed_in);
		cbs_pkg::byte_t chain;
		cbs_pkg::byte_t v;
		cbs_pkg::byte_t kb;
		chain = first_in ? seed_in : chain_q;
		if (op == cbs_pkg::OP_ENCODE) begin
			v = (data ^ chain) + key_byte(0);
			for (int r = 1; r <= cbs_pkg::Rounds; r++) begin
				kb = key_byte(r);
				v  = rol_byte(v, kb[7:5]);
				v  = v + {3'b000, kb[4:0]};
			end
			chain_q = v;
		end else begin
			v = data;
			for (int r = cbs_pkg::Rounds; r >= 1; r--) begin
				kb = key_byte(r);
				v  = v - {3'b000, kb[4:0]};
				v  = ror_byte(v, kb[7:5]);
			end
			v = v - key_byte(0);
			v = v ^ chain;
			chain_q = data;
		end
		return v;
	endfunction

	task automatic send_byte(cbs_pkg::op_t op, cbs_pkg::byte_t data, logic first_in,
			cbs_pkg::byte_t seed_in, logic typed, cbs_pkg::byte_t want);
		int unsigned    gap;
		cbs_pkg::byte_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		operation <= op;
		data_byte <= data;
		first     <= first_in;
		seed      <= seed_in;
		do @(posedge clk); while (!in_ready);
		pred = scramble_byte(op, data, first_in, seed_in);
		result_q.push_back(typed ? want : pred);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_keys(logic [cbs_pkg::KeyW-1:0] low_val,
			logic [cbs_pkg::KeyW-1:0] high_val);
		cfg_valid <= 1'b1;
		cfg_index <= cbs_pkg::REG_KEY_LOW;
		cfg_data  <= low_val;
		do @(posedge clk); while (!cfg_ready);
		key_low_q = low_val;
		cfg_index <= cbs_pkg::REG_KEY_HIGH;
		cfg_data  <= high_val;
		do @(posedge clk); while (!cfg_ready);
		key_high_q = high_val;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("%0t: timeout", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(20, 200);
				stall_pat  = 8'($urandom_range(0, 255)) | 8'h01;
			end
			mode_left--;
			pat_idx = pat_idx + 1'b1;
			unique case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= stall_pat[pat_idx];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$display("%0t: result_byte expected none actual %02h", $time, result_byte);
				err_cnt++;
			end else begin
				want_byte = result_q.pop_front();
				if (result_byte !== want_byte) begin
					$display("%0t: result_byte expected %02h actual %02h",
						$time, want_byte, result_byte);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		int unsigned              sent;
		int unsigned              pkt_len;
		logic                     noisy;
		cbs_pkg::op_t             pkt_op;
		cbs_pkg::op_t             op;
		cbs_pkg::byte_t           data;
		logic [cbs_pkg::KeyW-1:0] k_low;
		logic [cbs_pkg::KeyW-1:0] k_high;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (i == KEY_ROW_A) begin
				drain_results();
				write_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF);
			end
			if (i == KEY_ROW_B) begin
				drain_results();
				write_keys(32'h1F1F_1F1F, 32'h1F1F_1F1F);
			end
			send_byte(DIR_ROWS[i].op, DIR_ROWS[i].data, DIR_ROWS[i].first,
				DIR_ROWS[i].seed, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			unique case (ph)
				0: begin k_low = 32'hFFFF_FFFF; k_high = 32'h0000_0000; end
				1: begin k_low = 32'h0000_0000; k_high = 32'hFFFF_FFFF; end
				3: begin
					k_low  = $urandom() & 32'h1F1F_1F1F;
					k_high = $urandom() & 32'h1F1F_1F1F;
				end
				default: begin k_low = $urandom(); k_high = $urandom(); end
			endcase
			drain_results();
			write_keys(k_low, k_high);
			if (ph == 2) begin
				steady   = 1'b1;
				hold_req = 1'b1;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pkt_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 16);
				noisy   = ($urandom_range(0, 9) == 0);
				pkt_op  = cbs_pkg::op_t'($urandom_range(0, 1));
				for (int k = 0; k < pkt_len; k++) begin
					op   = noisy ? cbs_pkg::op_t'($urandom_range(0, 1)) : pkt_op;
					data = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 15) == 0) begin
						data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					send_byte(op, data, noisy ? 1'($urandom_range(0, 1)) : (k == 0),
						8'($urandom_range(0, 255)), 1'b0, 8'h00);
					sent++;
					if (sent == 60) begin
						steady = 1'b0;
					end
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (err_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
